FILE: rtl/rsz_pkg.sv
// ----------------------------------------------------------------------------
// rsz_pkg
// Shared types, codes and a saturating add helper for the report size table and its cells.
// ----------------------------------------------------------------------------
package rsz_pkg;

	localparam int RSZ_TABLE_ENTRIES = 32;

	localparam int KIND_W   = 2;
	localparam int ID_W     = 8;
	localparam int TYPE_W   = 2;
	localparam int KEY_W    = ID_W + TYPE_W;
	localparam int SIZE_W   = 16;
	localparam int IDX_W    = 5;
	localparam int BYTES_W  = 14;
	localparam int COUNT_W  = 6;
	localparam int BYTE_RND = 7;

	localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_KEY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_IDX = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

	localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

	// Item travelling down the row of cells.
	typedef struct packed {
		logic                valid;
		logic [KIND_W-1:0]   kind;
		logic [KEY_W-1:0]    key;
		logic [SIZE_W-1:0]   inc;
		logic [IDX_W-1:0]    idx;
		logic                found;
		logic                appended;
		logic [SIZE_W-1:0]   bits;
		logic [ID_W-1:0]     hit_id;
	} token_t;

	function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
		input logic [SIZE_W-1:0] b);
		logic [SIZE_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[SIZE_W] ? SIZE_MAX : sum[SIZE_W-1:0];
	endfunction

endpackage

FILE: rtl/rsz_cell.sv
// ----------------------------------------------------------------------------
// rsz_cell
// One table entry: holds a key and its bit size, and checks or updates it as
// an item passes through on its way to the next cell.
// ----------------------------------------------------------------------------
module rsz_cell #(
	parameter int CELL_IDX = 0,
	parameter int CNT_W    = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [CNT_W-1:0]     entry_total,
	input  rsz_pkg::token_t      tok_in,
	output rsz_pkg::token_t      tok_out
);
	import rsz_pkg::*;

	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);
	localparam bit IDX_REACH = CELL_IDX < (1 << IDX_W);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [KEY_W-1:0]  key_q;
	logic [SIZE_W-1:0] size_q;
	token_t            tok_q;
	token_t            tok_n;

	logic occupied;
	logic is_tail;
	logic settled;
	logic key_hit;
	logic do_append;
	logic idx_hit;
	logic do_write;
	logic [SIZE_W-1:0] new_size;

	assign occupied  = MY_POS < entry_total;
	assign is_tail   = MY_POS == entry_total;
	assign settled   = tok_in.found || tok_in.appended;
	assign key_hit   = tok_in.valid && occupied && !settled && (key_q == tok_in.key)
		&& (tok_in.kind == KIND_ADD || tok_in.kind == KIND_KEY);
	assign do_append = tok_in.valid && !settled && is_tail && (tok_in.kind == KIND_ADD);
	assign idx_hit   = tok_in.valid && occupied && IDX_REACH && (tok_in.kind == KIND_IDX)
		&& (tok_in.idx == MY_IDX);
	// a new entry adds its increment to zero
	assign new_size  = sat_add(do_append ? '0 : size_q, tok_in.inc);
	assign do_write  = (key_hit && tok_in.kind == KIND_ADD) || do_append;

	always_comb begin
		tok_n = tok_in;
		if (key_hit) begin
			tok_n.found = 1'b1;
			tok_n.bits  = (tok_in.kind == KIND_ADD) ? new_size : size_q;
		end
		if (do_append) begin
			tok_n.appended = 1'b1;
			tok_n.bits     = new_size;
		end
		if (idx_hit) begin
			tok_n.found  = 1'b1;
			tok_n.bits   = size_q;
			tok_n.hit_id = key_q[KEY_W-1:TYPE_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && do_write) begin
			key_q  <= tok_in.key;
			size_q <= new_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_n;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: rtl/report_size_table.sv
// ----------------------------------------------------------------------------
// report_size_table
// Per-report bit size accumulator keyed by report ID and report type.
//
//   channel | signals                                   | role
//   in      | in_valid/in_ready, kind .. entry_index    | add / key or index lookup
//   out     | out_valid/out_ready, found .. table_full  | one result per item
//
// Each item walks the row of TABLE_ENTRIES cells, one cell per cycle while the row
// is not held, and then lands in the output register. The next item is taken only
// after the last one has left the row, so one item is in the row at a time.
// The next item is taken while a result waits.
// Reset empties the table (count to zero); entry contents need no clearing.
// An untaken result stalls the whole row once the next item reaches the end.
// ----------------------------------------------------------------------------
module report_size_table #(
	parameter int TABLE_ENTRIES = rsz_pkg::RSZ_TABLE_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rsz_pkg::KIND_W-1:0]  kind,
	input  logic [rsz_pkg::ID_W-1:0]    report_id,
	input  logic [rsz_pkg::TYPE_W-1:0]  report_type,
	input  logic [rsz_pkg::SIZE_W-1:0]  increment,
	input  logic [rsz_pkg::IDX_W-1:0]   entry_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [rsz_pkg::SIZE_W-1:0]  size_bits,
	output logic [rsz_pkg::BYTES_W-1:0] size_bytes,
	output logic [rsz_pkg::COUNT_W-1:0] entry_count,
	output logic                        table_full
);
	import rsz_pkg::*;

	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

	token_t tok [TABLE_ENTRIES+1];
	token_t last;

	logic [CNT_W-1:0] entry_total_q;
	logic             busy_q;
	logic             out_valid_q;
	logic             adv;
	logic             in_acc;
	logic             retire;

	logic                found_q;
	logic [SIZE_W-1:0]   bits_q;
	logic [BYTES_W-1:0]  bytes_q;
	logic [COUNT_W-1:0]  count_q;
	logic                full_q;

	logic                res_found;
	logic                res_full;
	logic [ID_W-1:0]     res_id;
	logic [BYTES_W-1:0]  res_bytes;
	logic [BYTES_W-1:0]  rounded;
	logic [CNT_W-1:0]    next_total;

	assign last   = tok[TABLE_ENTRIES];
	// hold the row while a finished item waits at the end
	assign adv    = !(last.valid && out_valid_q && !out_ready);
	assign in_ready = !busy_q;
	assign in_acc = in_valid && in_ready;
	assign retire = last.valid && adv;

	always_comb begin
		tok[0]          = '0;
		tok[0].valid    = in_acc;
		tok[0].kind     = kind;
		tok[0].key      = {report_id, report_type};
		tok[0].inc      = increment;
		tok[0].idx      = entry_index;
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		rsz_cell #(
			.CELL_IDX (i),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.entry_total (entry_total_q),
			.tok_in      (tok[i]),
			.tok_out     (tok[i+1])
		);
	end

	// result of the item leaving the row
	assign rounded    = BYTES_W'(({1'b0, last.bits} + (SIZE_W+1)'(BYTE_RND)) >> 3);
	assign res_found  = last.found;
	assign res_full   = (last.kind == KIND_ADD) && !last.found && !last.appended;
	assign res_id     = (last.kind == KIND_IDX) ? last.hit_id : last.key[KEY_W-1:TYPE_W];
	assign next_total = entry_total_q + CNT_W'(last.appended);

	always_comb begin
		unique case (last.kind)
			KIND_ADD, KIND_KEY: res_bytes = rounded + BYTES_W'(res_id != '0);
			KIND_IDX:           res_bytes = last.found ?
				rounded + BYTES_W'(res_id != '0) : '0;
			KIND_NOP:           res_bytes = '0;
			default:            res_bytes = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_total_q <= '0;
			busy_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (retire) begin
				entry_total_q <= next_total;
			end
			busy_q      <= in_acc || (busy_q && !retire);
			// a retiring item refills the output even when the old result leaves
			out_valid_q <= retire || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			found_q <= res_found && (last.kind != KIND_ADD || !last.appended);
			bits_q  <= last.bits;
			bytes_q <= res_bytes;
			count_q <= COUNT_W'(next_total);
			full_q  <= res_full;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign size_bits   = bits_q;
	assign size_bytes  = bytes_q;
	assign entry_count = count_q;
	assign table_full  = full_q;

`ifndef NO_ASSERTIONS
	a_idle_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !last.valid)
		else $error("item in the row while not busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_total_q <= CNT_FULL)
		else $error("entry count above table size");

	a_full_no_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && full_q |-> !found_q && bits_q == '0)
		else $error("refused add reports a size");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> busy_q)
		else $error("accepted item not tracked");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!retire |=> $stable(entry_total_q))
		else $error("entry count moved without a retiring item");
`endif

endmodule
